FILE: rtl/sequence_gap_trust_table_macros.svh
// ----------------------------------------------------------------------------
// sequence_gap_trust_table_macros.svh
// Assertion macros used by the checker file of the trust table.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_GAP_TRUST_TABLE_MACROS_SVH
`define SEQUENCE_GAP_TRUST_TABLE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SGTT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgtt: assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SGTT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgtt: assertion failed");

`endif

FILE: rtl/sgtt_pkg.sv
// ----------------------------------------------------------------------------
// sgtt_pkg
// Types and constants of the sequence gap trust table.
// ----------------------------------------------------------------------------
package sgtt_pkg;

	localparam int NODE_COUNT = 256;
	localparam int NODE_AW    = $clog2(NODE_COUNT);

	// shared divider: dividend covers the blend sum, divisor covers gap + 1
	localparam int DIVD_W = 21;
	localparam int DIVS_W = 33;

	localparam logic [15:0] TRUST_SCALE_RST = 16'd1000;
	localparam logic [4:0]  ALPHA_NUM_RST   = 5'd2;
	localparam logic [4:0]  ALPHA_DEN_RST   = 5'd10;

	typedef enum logic [1:0] {
		ST_FIRST   = 2'd0,
		ST_UPDATED = 2'd1,
		ST_STALE   = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_TRUST_SCALE = 2'd0,
		REG_ALPHA_NUM   = 2'd1,
		REG_ALPHA_DEN   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] node_id;
		logic [31:0] seq;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] missed;
		logic [15:0] trust_out;
		logic [31:0] received_count;
		logic [31:0] missing_count;
	} result_t;

	typedef struct packed {
		logic [31:0] newest_seq;
		logic [31:0] rx_count;
		logic [31:0] miss_count;
		logic [15:0] trust;
	} entry_t;

endpackage

FILE: rtl/sgtt_ram.sv
// ----------------------------------------------------------------------------
// sgtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sgtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/sgtt_div.sv
// ----------------------------------------------------------------------------
// sgtt_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgtt_div import sgtt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] divs_q;
	logic [DIVD_W-1:0] quo_q;

	logic [DIVS_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = (trial >= {1'b0, divs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift dividend bits out the top, quotient bits in the bottom
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			divs_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= DIVS_W'(trial - {1'b0, divs_q});
			end else begin
				rem_q <= trial[DIVS_W-1:0];
			end
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/sequence_gap_trust_table.sv
// ----------------------------------------------------------------------------
// sequence_gap_trust_table
// Per-node delivery trust kept as a rounded exponential average of gap
// samples, with per-node report and gap totals.
// ----------------------------------------------------------------------------
// Pulse start with a report (node id, sequence number) while busy is low; the
// beat is taken at that edge. Exactly one result beat follows, shown on rsp
// for a single cycle with done high. The receiver cannot hold it off, so
// capture it on that cycle. For an out-of-range id, a first report or a stale
// sequence done is raised straight from the table read state that the start
// edge enters; an update goes on from the table read through two passes of
// the one shared bit-serial divider (sample = scale / (gap + 1), then the
// rounded blend divided by the denominator), with the blend multiply state
// between them, and done rises as the second pass ends.
// busy drops in the done cycle, so the next start can land on the edge after.
// Node state lives in one RAM with a registered read; per-node valid bits in
// flops are cleared by reset, so no clearing pass is needed. Configuration
// writes are always ready and should only be issued while busy is low.
// ----------------------------------------------------------------------------
module sequence_gap_trust_table import sgtt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    req,
	output logic        done,
	output result_t     rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV1,
		S_MUL,
		S_DIV2
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] trust_scale_q;
	logic [4:0]  alpha_num_q;
	logic [4:0]  alpha_den_q;

	// captured report and working values
	logic [NODE_AW-1:0]  id_q;
	logic [31:0]         seq_q;
	logic                in_range_q;
	entry_t              entry_q;
	logic [31:0]         missed_q;
	logic [15:0]         sample_q;
	logic [NODE_COUNT-1:0] valid_q;

	result_t rsp_q;
	logic    done_q;

	// RAM and divider hookup
	logic                ram_we;
	logic [NODE_AW-1:0]  ram_waddr;
	entry_t              ram_wentry;
	logic [NODE_AW-1:0]  ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t              rd_entry;

	logic                div_go;
	logic [DIVD_W-1:0]   div_dividend;
	logic [DIVS_W-1:0]   div_divisor;
	logic                div_done;
	logic [DIVD_W-1:0]   div_quot;

	logic                accept;
	logic [NODE_AW-1:0]  idx;
	logic                entry_valid;
	logic [31:0]         missed_c;
	logic                is_newer;
	logic [4:0]          d_eff;
	logic [4:0]          a_eff;
	logic [DIVD_W-1:0]   acc_c;
	entry_t              upd_entry;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign idx         = id_q;
	assign entry_valid = valid_q[idx];
	assign rd_entry    = entry_t'(ram_rdata);
	assign missed_c    = seq_q - rd_entry.newest_seq - 32'd1;
	assign is_newer    = (seq_q > rd_entry.newest_seq);

	// Clamp the weights: a zero denominator acts as one, numerator <= denominator.
	assign d_eff = (alpha_den_q == 5'd0) ? 5'd1 : alpha_den_q;
	assign a_eff = (alpha_num_q > d_eff) ? d_eff : alpha_num_q;

	// Blend sum with the rounding half-denominator; at most 31 * 65535 + 15.
	assign acc_c = ({{(DIVD_W-5){1'b0}}, a_eff} * {{(DIVD_W-16){1'b0}}, sample_q})
		+ ({{(DIVD_W-5){1'b0}}, 5'(d_eff - a_eff)}
			* {{(DIVD_W-16){1'b0}}, entry_q.trust})
		+ {{(DIVD_W-5){1'b0}}, 1'b0, d_eff[4:1]};

	// Updated entry once the blend division lands.
	always_comb begin
		upd_entry.newest_seq = seq_q;
		upd_entry.rx_count   = entry_q.rx_count + 32'd1;
		upd_entry.miss_count = entry_q.miss_count + missed_q;
		upd_entry.trust      = div_quot[15:0];
	end

	// Read the node entry on the accept edge so it is ready in S_READ.
	assign ram_raddr = req.node_id[NODE_AW-1:0];
	assign ram_waddr = idx;

	// Write back on a first report (fresh entry) or at the end of an update.
	always_comb begin
		ram_we     = 1'b0;
		ram_wentry = upd_entry;
		if (state_q == S_READ && in_range_q && !entry_valid) begin
			ram_we                = 1'b1;
			ram_wentry.newest_seq = seq_q;
			ram_wentry.rx_count   = 32'd1;
			ram_wentry.miss_count = 32'd0;
			ram_wentry.trust      = trust_scale_q;
		end else if (state_q == S_DIV2 && div_done) begin
			ram_we = 1'b1;
		end
	end

	// Divider: first pass forms the sample, second pass divides the blend.
	always_comb begin
		div_go       = 1'b0;
		div_dividend = {{(DIVD_W-16){1'b0}}, trust_scale_q};
		div_divisor  = {1'b0, missed_c} + DIVS_W'(1);
		if (state_q == S_READ && in_range_q && entry_valid && is_newer) begin
			div_go = 1'b1;
		end else if (state_q == S_MUL) begin
			div_go       = 1'b1;
			div_dividend = acc_c;
			div_divisor  = {{(DIVS_W-5){1'b0}}, d_eff};
		end
	end

	sgtt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NODE_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sgtt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Configuration writes; an index past the register list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trust_scale_q <= TRUST_SCALE_RST;
			alpha_num_q   <= ALPHA_NUM_RST;
			alpha_den_q   <= ALPHA_DEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TRUST_SCALE: trust_scale_q <= cfg_data;
				REG_ALPHA_NUM:   alpha_num_q   <= cfg_data[4:0];
				REG_ALPHA_DEN:   alpha_den_q   <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: state, valid bits and the registered result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (!in_range_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!entry_valid) begin
						valid_q[idx] <= 1'b1;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else if (!is_newer) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: capture the report, hold the entry, build the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q       <= req.node_id[NODE_AW-1:0];
			seq_q      <= req.seq;
			in_range_q <= ({1'b0, req.node_id} < 17'(NODE_COUNT));
		end
		if (state_q == S_READ) begin
			entry_q  <= rd_entry;
			missed_q <= missed_c;
			if (!in_range_q) begin
				rsp_q.status         <= ST_RANGE;
				rsp_q.missed         <= 32'd0;
				rsp_q.trust_out      <= 16'd0;
				rsp_q.received_count <= 32'd0;
				rsp_q.missing_count  <= 32'd0;
			end else if (!entry_valid) begin
				rsp_q.status         <= ST_FIRST;
				rsp_q.missed         <= 32'd0;
				rsp_q.trust_out      <= trust_scale_q;
				rsp_q.received_count <= 32'd1;
				rsp_q.missing_count  <= 32'd0;
			end else begin
				// stale report: show the entry untouched
				rsp_q.status         <= ST_STALE;
				rsp_q.missed         <= 32'd0;
				rsp_q.trust_out      <= rd_entry.trust;
				rsp_q.received_count <= rd_entry.rx_count;
				rsp_q.missing_count  <= rd_entry.miss_count;
			end
		end
		if (state_q == S_DIV1 && div_done) begin
			sample_q <= div_quot[15:0];
		end
		if (state_q == S_DIV2 && div_done) begin
			rsp_q.status         <= ST_UPDATED;
			rsp_q.missed         <= missed_q;
			rsp_q.trust_out      <= upd_entry.trust;
			rsp_q.received_count <= upd_entry.rx_count;
			rsp_q.missing_count  <= upd_entry.miss_count;
		end
	end

endmodule

FILE: rtl/sgtt_chk.sv
// ----------------------------------------------------------------------------
// sgtt_chk
// Port-level checks of the trust table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequence_gap_trust_table_macros.svh"

module sgtt_chk import sgtt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input result_t     rsp
);

	logic not_upd_beat;
	logic range_beat;
	logic first_beat;
	logic range_zero;
	logic first_counts;

	assign not_upd_beat = done && (rsp.status != ST_UPDATED);
	assign range_beat   = done && (rsp.status == ST_RANGE);
	assign first_beat   = done && (rsp.status == ST_FIRST);
	assign range_zero   = (rsp.trust_out == 16'd0) && (rsp.received_count == 32'd0)
		&& (rsp.missing_count == 32'd0);
	assign first_counts = (rsp.received_count == 32'd1) && (rsp.missing_count == 32'd0);

	`SGTT_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
	`SGTT_ASSERT_IMP(a_done_ends_work, done, $past(busy))
	`SGTT_ASSERT_IMP(a_missed_only_update, not_upd_beat, rsp.missed == 32'd0)
	`SGTT_ASSERT_IMP(a_range_zero, range_beat, range_zero)
	`SGTT_ASSERT_IMP(a_first_counts, first_beat, first_counts)

endmodule

bind sequence_gap_trust_table sgtt_chk u_sgtt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.rsp       (rsp)
);
